[rtl/bds_pkg.sv]
// ----------------------------------------------------------------------------
// bds_pkg
// shared types and constants of the 2x2 box downsampler
// ----------------------------------------------------------------------------
package bds_pkg;

    // defaults for the top level parameters
    localparam int DEF_MAX_OUT_WIDTH = 2048;
    localparam int DEF_CHANNEL_BITS  = 16;

    // one lane per colour channel
    localparam int NUM_LANES = 4;

    // configuration register widths
    localparam int OUT_WIDTH_BITS   = 12;
    localparam int OUT_HEIGHT_BITS  = 13;
    localparam int OUT_ROW_BITS     = 12;
    localparam int OUT_HEIGHT_LIMIT = 4096;

    // apb register map
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    typedef enum logic {
        REG_OUT_WIDTH  = 1'b0,
        REG_OUT_HEIGHT = 1'b1
    } t_reg_idx;

    // frame position marks carried alongside a result
    typedef struct packed {
        logic row_end;
        logic frame_end;
    } t_marks;

endpackage

[rtl/box_downsample_2x2_top.sv]
// ----------------------------------------------------------------------------
// box_downsample_2x2_top
// 2x2 box-filter downsampler for a raster stream of four-channel pixels
// ----------------------------------------------------------------------------
// Source pixels come in raster order on the slave stream, one request per
// pixel, from an image exactly twice the programmed output size in each
// direction. The block takes one pixel every clock for as long as the
// output side drains; the figure is set by the line buffer, which has one
// write and one read port and is touched at most once per pixel. Once the
// odd-column pixel of an odd row completes a result, it is registered in
// the output stage (skid slot if stalled); tlast marks the last pixel of an
// output row and tuser the last pixel of the frame. Write out_width
// (address 0) and out_height (address 4) only while the block is idle;
// either write restarts the frame at row 0, column 0. A value of 0 acts as
// 1 and values above the supported maximum are clamped. The line buffer
// needs no clearing after reset.
// ----------------------------------------------------------------------------
module box_downsample_2x2_top #(
    parameter int MAX_OUT_WIDTH = bds_pkg::DEF_MAX_OUT_WIDTH,
    parameter int CHANNEL_BITS  = bds_pkg::DEF_CHANNEL_BITS,
    parameter int DATA_W        = ((bds_pkg::NUM_LANES * CHANNEL_BITS + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // red_in, green_in, blue_in, alpha_in from bit 0 up, zero padded
    input  logic [DATA_W-1:0]                  i_s_axis_tdata,
    // master stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // red_out, green_out, blue_out, alpha_out from bit 0 up, zero padded
    output logic [DATA_W-1:0]                  o_m_axis_tdata,
    // row_end
    output logic                               o_m_axis_tlast,
    // frame_end
    output logic                               o_m_axis_tuser,
    // apb configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bds_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [bds_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [bds_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                               pready
);

    import bds_pkg::*;

    localparam int AW     = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int SUM_W  = CHANNEL_BITS + 1;
    localparam int RAM_W  = NUM_LANES * SUM_W;
    localparam int EXT_W  = 14;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [OUT_WIDTH_BITS-1:0]  r_out_width;
    logic [OUT_HEIGHT_BITS-1:0] r_out_height;
    logic [AW-1:0]              r_last_x;
    logic [OUT_ROW_BITS-1:0]    r_last_y;
    logic [AW-1:0]              n_last_x;
    logic [OUT_ROW_BITS-1:0]    n_last_y;
    logic [EXT_W-1:0]           w_ext;
    logic [EXT_W-1:0]           h_ext;
    logic                       cfg_wr;
    t_reg_idx                   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[2]);

    // clamp the written size once, at write time
    always_comb begin
        w_ext = {{(EXT_W-OUT_WIDTH_BITS){1'b0}}, pwdata[OUT_WIDTH_BITS-1:0]};
        if (w_ext == '0) begin
            w_ext = EXT_W'(1);
        end
        if (w_ext > EXT_W'(MAX_OUT_WIDTH)) begin
            w_ext = EXT_W'(MAX_OUT_WIDTH);
        end
        n_last_x = AW'(w_ext - EXT_W'(1));

        h_ext = {{(EXT_W-OUT_HEIGHT_BITS){1'b0}}, pwdata[OUT_HEIGHT_BITS-1:0]};
        if (h_ext == '0) begin
            h_ext = EXT_W'(1);
        end
        if (h_ext > EXT_W'(OUT_HEIGHT_LIMIT)) begin
            h_ext = EXT_W'(OUT_HEIGHT_LIMIT);
        end
        n_last_y = OUT_ROW_BITS'(h_ext - EXT_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_width  <= OUT_WIDTH_BITS'(1);
            r_out_height <= OUT_HEIGHT_BITS'(1);
            r_last_x     <= '0;
            r_last_y     <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_OUT_WIDTH: begin
                    r_out_width <= pwdata[OUT_WIDTH_BITS-1:0];
                    r_last_x    <= n_last_x;
                end
                REG_OUT_HEIGHT: begin
                    r_out_height <= pwdata[OUT_HEIGHT_BITS-1:0];
                    r_last_y     <= n_last_y;
                end
                default: begin
                    r_out_width <= r_out_width;
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_OUT_WIDTH:  prdata = CFG_DATA_BITS'(r_out_width);
            REG_OUT_HEIGHT: prdata = CFG_DATA_BITS'(r_out_height);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // source position: output column / row plus the parity within the pair
    // ------------------------------------------------------------------
    logic                    r_x_odd;
    logic [AW-1:0]           r_x;
    logic                    r_y_odd;
    logic [OUT_ROW_BITS-1:0] r_y;
    logic                    n_x_odd;
    logic [AW-1:0]           n_x;
    logic                    n_y_odd;
    logic [OUT_ROW_BITS-1:0] n_y;
    logic                    in_acc;
    logic                    row_last;
    t_marks                  marks;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign row_last = r_x_odd && (r_x == r_last_x);

    always_comb begin
        n_x_odd = r_x_odd;
        n_x     = r_x;
        n_y_odd = r_y_odd;
        n_y     = r_y;
        if (in_acc) begin
            n_x_odd = !r_x_odd;
            if (row_last) begin
                n_x     = '0;
                n_y_odd = !r_y_odd;
                if (r_y_odd) begin
                    n_y = (r_y == r_last_y) ? '0 : r_y + OUT_ROW_BITS'(1);
                end
            end else if (r_x_odd) begin
                n_x = r_x + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_x_odd <= 1'b0;
            r_x     <= '0;
            r_y_odd <= 1'b0;
            r_y     <= '0;
        end else begin
            r_x_odd <= n_x_odd;
            r_x     <= n_x;
            r_y_odd <= n_y_odd;
            r_y     <= n_y;
        end
    end

    assign marks.row_end   = row_last;
    assign marks.frame_end = row_last && r_y_odd && (r_y == r_last_y);

    // ------------------------------------------------------------------
    // line buffer of pair sums, one entry per output column
    // written on even rows, read at the even pixel of an odd row so the
    // registered data is ready when the odd pixel arrives
    // ------------------------------------------------------------------
    logic             ram_wr;
    logic             ram_rd;
    logic [RAM_W-1:0] ram_wdata;
    logic [RAM_W-1:0] ram_rdata;

    assign ram_wr = in_acc && r_x_odd && !r_y_odd;
    assign ram_rd = in_acc && !r_x_odd && r_y_odd;

    bds_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_OUT_WIDTH),
        .AW    (AW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr),
        .i_wr_addr (r_x),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_rd),
        .i_rd_addr (r_x),
        .o_rd_data (ram_rdata)
    );

    // ------------------------------------------------------------------
    // channel lanes
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] res_data;
    logic [CHANNEL_BITS-1:0] lane_avg [NUM_LANES];

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        bds_lane #(
            .CHANNEL_BITS (CHANNEL_BITS)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_hold     (in_acc && !r_x_odd),
            .i_px       (i_s_axis_tdata[g*CHANNEL_BITS +: CHANNEL_BITS]),
            .i_buf_sum  (ram_rdata[g*SUM_W +: SUM_W]),
            .o_pair_sum (ram_wdata[g*SUM_W +: SUM_W]),
            .o_avg      (lane_avg[g])
        );
    end

    always_comb begin
        res_data = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            res_data[i*CHANNEL_BITS +: CHANNEL_BITS] = lane_avg[i];
        end
    end

    // ------------------------------------------------------------------
    // merge and output stage
    // ------------------------------------------------------------------
    bds_out #(
        .DATA_W (DATA_W)
    ) u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_acc && r_x_odd && r_y_odd),
        .i_data   (res_data),
        .i_marks  (marks),
        .o_ready  (o_s_axis_tready),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast),
        .o_tuser  (o_m_axis_tuser)
    );

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // end of frame is always also end of row
    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (!o_m_axis_tuser || o_m_axis_tlast))
        else $error("frame end without row end");

    // input only stalls behind a result that was itself stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> $past(o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without a blocked result");

    // the line buffer is never written and read in the same cycle
    a_ram_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_wr && ram_rd))
        else $error("line buffer write and read collide");

    // a register write restarts the frame
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_x == '0) && !r_x_odd && (r_y == '0) && !r_y_odd)
        else $error("frame position not cleared by register write");

endmodule

[rtl/bds_ram.sv]
// ----------------------------------------------------------------------------
// bds_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bds_ram #(
    parameter int WIDTH = 68,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/bds_lane.sv]
// ----------------------------------------------------------------------------
// bds_lane
// one colour channel: holds the even-column pixel, forms the pair sum and
// the rounded 2x2 average
// ----------------------------------------------------------------------------
module bds_lane #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_hold,
    input  logic [CHANNEL_BITS-1:0] i_px,
    input  logic [CHANNEL_BITS:0]   i_buf_sum,
    output logic [CHANNEL_BITS:0]   o_pair_sum,
    output logic [CHANNEL_BITS-1:0] o_avg
);

    logic [CHANNEL_BITS-1:0] r_held;
    logic [CHANNEL_BITS-1:0] n_held;
    logic [CHANNEL_BITS+1:0] block_sum;

    always_comb begin
        n_held = i_hold ? i_px : r_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else begin
            r_held <= n_held;
        end
    end

    assign o_pair_sum = {1'b0, r_held} + {1'b0, i_px};

    // buffered pair from the row above plus the current pair, rounded
    assign block_sum = {1'b0, i_buf_sum} + {2'b00, r_held} + {2'b00, i_px}
                     + (CHANNEL_BITS+2)'(2);
    assign o_avg     = block_sum[CHANNEL_BITS+1:2];

endmodule

[rtl/bds_out.sv]
// ----------------------------------------------------------------------------
// bds_out
// holds the merged lane averages and marks as one result: output register
// with a skid slot so the input side keeps flowing
// ----------------------------------------------------------------------------
module bds_out #(
    parameter int DATA_W = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [DATA_W-1:0]   i_data,
    input  bds_pkg::t_marks     i_marks,
    output logic                o_ready,
    output logic                o_tvalid,
    input  logic                i_tready,
    output logic [DATA_W-1:0]   o_tdata,
    output logic                o_tlast,
    output logic                o_tuser
);

    import bds_pkg::*;

    logic              r_main_valid;
    logic [DATA_W-1:0] r_main_data;
    t_marks            r_main_marks;
    logic              r_skid_valid;
    logic [DATA_W-1:0] r_skid_data;
    t_marks            r_skid_marks;
    logic              pop;

    assign pop = r_main_valid && i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop || !r_main_valid) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_valid;
            end
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop || !r_main_valid) begin
            if (r_skid_valid) begin
                r_main_data  <= r_skid_data;
                r_main_marks <= r_skid_marks;
            end else if (i_valid) begin
                r_main_data  <= i_data;
                r_main_marks <= i_marks;
            end
        end else if (i_valid) begin
            r_skid_data  <= i_data;
            r_skid_marks <= i_marks;
        end
    end

    assign o_ready  = !r_skid_valid;
    assign o_tvalid = r_main_valid;
    assign o_tdata  = r_main_data;
    assign o_tlast  = r_main_marks.row_end;
    assign o_tuser  = r_main_marks.frame_end;

endmodule
